/* design/stna_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stna_pkg
// Shared types and constants for the seconds/nanoseconds timestamp ALU.
// ----------------------------------------------------------------------------
package stna_pkg;

  localparam int SEC_BITS_DEF = 48;
  localparam int NSEC_W       = 30;
  localparam int FREQ_W       = 33;
  localparam int DIV_W        = 32;
  localparam int REM_W        = DIV_W + 1;
  localparam int PROD_W       = FREQ_W + NSEC_W;

  localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);
  localparam logic [NSEC_W-1:0] NSEC_MAX   = NSEC_W'(999999999);
  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000000000);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_CMP = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CYC = 3'd4
  } cmd_t;

endpackage

/* design/stna_div_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stna_div_step
// One restoring division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the low end of the dividend word.
// ----------------------------------------------------------------------------
module stna_div_step #(
  parameter int DQ_W = 48
) (
  input  logic                         act,
  input  logic [stna_pkg::REM_W-1:0]   rem_in,
  input  logic [DQ_W-1:0]              dq_in,
  input  logic [stna_pkg::DIV_W-1:0]   dv,
  output logic [stna_pkg::REM_W-1:0]   rem_out,
  output logic [DQ_W-1:0]              dq_out
);

  logic [stna_pkg::REM_W-1:0] trial;
  logic                       ge;

  // partial remainder stays below the divisor, so the shifted value fits
  assign trial = {rem_in[stna_pkg::REM_W-2:0], dq_in[DQ_W-1]};
  assign ge    = trial >= {1'b0, dv};

  always_comb begin
    if (act) begin
      rem_out = ge ? (trial - {1'b0, dv}) : trial;
      dq_out  = {dq_in[DQ_W-2:0], ge};
    end else begin
      rem_out = rem_in;
      dq_out  = dq_in;
    end
  end

endmodule

/* design/sec_nsec_time_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sec_nsec_time_alu_core
// Pipelined add, subtract, compare, divide and cycle-difference on
// seconds-plus-nanoseconds timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation per item: the command in s_tuser, both
//   timestamps and the divisor in s_tdata. m_* returns exactly one result
//   item per operation, in order.
//   cfg_wr_en/cfg_wr_data load the cpu frequency used by cycle difference;
//   write it only while no operation is in flight.
// Pipeline: an entry stage, then one bit of seconds division per stage, a
//   multiply stage, an add stage, then 33 stages of a second division
//   shared by the nanosecond divide and the cycle scaling.
// Throughput: one item per cycle while the pipeline is not stalled.
// Reset: rst clears every valid bit and sets the frequency to 1 GHz.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sec_nsec_time_alu_core #(
  parameter int SEC_BITS = stna_pkg::SEC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [stna_pkg::FREQ_W-1:0]           cfg_wr_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // a_sec, a_nsec, b_sec, b_nsec, divisor (lowest bit first)
  input  logic [((2*SEC_BITS+92+7)/8)*8-1:0]    s_tdata,
  // command
  input  logic [2:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // res_sec, res_nsec, is_less, is_equal, is_greater, cycle_count, div_zero
  output logic [((SEC_BITS+67+7)/8)*8-1:0]      m_tdata
);

  localparam int NW     = stna_pkg::NSEC_W;
  localparam int FW     = stna_pkg::FREQ_W;
  localparam int DW     = stna_pkg::DIV_W;
  localparam int RW     = stna_pkg::REM_W;
  localparam int PW     = stna_pkg::PROD_W;
  localparam int OUT_TW = ((SEC_BITS+67+7)/8)*8;
  localparam int NP     = SEC_BITS + 36;
  localparam int MUL_I  = SEC_BITS + 1;
  localparam int ADD_I  = SEC_BITS + 2;
  localparam int C2_I   = SEC_BITS + 3;
  localparam int OFS_AN = SEC_BITS;
  localparam int OFS_BS = SEC_BITS + NW;
  localparam int OFS_BN = 2*SEC_BITS + NW;
  localparam int OFS_DV = 2*SEC_BITS + 2*NW;

  typedef struct packed {
    stna_pkg::cmd_t      cmd;
    logic                neg;
    logic                brw;
    logic                dz;
    logic                lt;
    logic                eq;
    logic                gt;
    logic [SEC_BITS-1:0] sec;
    logic [RW-1:0]       rem;
    logic [FW-1:0]       nlo;
    logic [PW-1:0]       prod;
    logic [NW-1:0]       nsec;
    logic [DW-1:0]       dv;
  } stage_t;

  logic [FW-1:0]       cpu_freq_hz;
  stage_t              pl [NP];
  stage_t              pl_next [NP];
  logic [NP-1:0]       vld;
  logic                en;

  logic [SEC_BITS-1:0] res_sec;
  logic [NW-1:0]       res_nsec;
  logic                is_less;
  logic                is_equal;
  logic                is_greater;
  logic [FW-1:0]       cycle_count;
  logic                div_zero;

  logic [SEC_BITS-1:0] res_sec_next;
  logic [NW-1:0]       res_nsec_next;
  logic                is_less_next;
  logic                is_equal_next;
  logic                is_greater_next;
  logic [FW-1:0]       cycle_count_next;
  logic                div_zero_next;

  logic [RW-1:0]       c1_rem [SEC_BITS];
  logic [SEC_BITS-1:0] c1_dq  [SEC_BITS];
  logic [RW-1:0]       c2_rem [FW];
  logic [FW-1:0]       c2_dq  [FW];

  // input fields
  stna_pkg::cmd_t      in_cmd;
  logic [SEC_BITS-1:0] in_as;
  logic [SEC_BITS-1:0] in_bs;
  logic [NW-1:0]       in_an_raw;
  logic [NW-1:0]       in_bn_raw;
  logic [NW-1:0]       in_an;
  logic [NW-1:0]       in_bn;
  logic [DW-1:0]       in_dv;
  logic [NW:0]         ns_sum;
  logic                ns_carry;
  logic                ns_borrow;

  assign in_cmd    = stna_pkg::cmd_t'(s_tuser[2:0]);
  assign in_as     = s_tdata[SEC_BITS-1:0];
  assign in_an_raw = s_tdata[OFS_AN +: NW];
  assign in_bs     = s_tdata[OFS_BS +: SEC_BITS];
  assign in_bn_raw = s_tdata[OFS_BN +: NW];
  assign in_dv     = s_tdata[OFS_DV +: DW];
  assign in_an     = (in_an_raw > stna_pkg::NSEC_MAX) ? stna_pkg::NSEC_MAX : in_an_raw;
  assign in_bn     = (in_bn_raw > stna_pkg::NSEC_MAX) ? stna_pkg::NSEC_MAX : in_bn_raw;
  assign ns_sum    = {1'b0, in_an} + {1'b0, in_bn};
  assign ns_carry  = ns_sum >= {1'b0, stna_pkg::NS_PER_SEC};
  assign ns_borrow = in_an < in_bn;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_freq_hz <= stna_pkg::FREQ_RESET;
    end else if (cfg_wr_en) begin
      cpu_freq_hz <= cfg_wr_data;
    end
  end

  // division steps
  genvar gi;
  generate
    for (gi = 0; gi < SEC_BITS; gi++) begin : g_c1
      stna_div_step #(.DQ_W(SEC_BITS)) u_step (
        .act     ((pl[gi].cmd == stna_pkg::CMD_DIV) && !pl[gi].dz),
        .rem_in  (pl[gi].rem),
        .dq_in   (pl[gi].sec),
        .dv      (pl[gi].dv),
        .rem_out (c1_rem[gi]),
        .dq_out  (c1_dq[gi])
      );
    end
    for (gi = 0; gi < FW; gi++) begin : g_c2
      stna_div_step #(.DQ_W(FW)) u_step (
        .act     (((pl[ADD_I+gi].cmd == stna_pkg::CMD_DIV) && !pl[ADD_I+gi].dz) ||
                  (pl[ADD_I+gi].cmd == stna_pkg::CMD_CYC)),
        .rem_in  (pl[ADD_I+gi].rem),
        .dq_in   (pl[ADD_I+gi].nlo),
        .dv      (pl[ADD_I+gi].dv),
        .rem_out (c2_rem[gi]),
        .dq_out  (c2_dq[gi])
      );
    end
  endgenerate

  always_comb begin
    stage_t        e;
    stage_t        m;
    stage_t        a;
    logic [FW-1:0] mx;
    logic [NW-1:0] my;
    logic [PW-1:0] sum;

    // entry stage
    e      = '0;
    e.cmd  = in_cmd;
    e.nsec = in_an;
    e.dv   = in_dv;
    case (in_cmd)
      stna_pkg::CMD_ADD: begin
        e.sec  = in_as + in_bs + SEC_BITS'(ns_carry);
        e.nsec = ns_carry ? NW'(ns_sum - {1'b0, stna_pkg::NS_PER_SEC}) : ns_sum[NW-1:0];
      end
      stna_pkg::CMD_SUB: begin
        e.sec  = in_as - in_bs - SEC_BITS'(ns_borrow);
        e.nsec = ns_borrow ? NW'(in_an + stna_pkg::NS_PER_SEC - in_bn) : (in_an - in_bn);
      end
      stna_pkg::CMD_CMP: begin
        e.lt = ($signed(in_as) < $signed(in_bs)) || ((in_as == in_bs) && ns_borrow);
        e.eq = (in_as == in_bs) && (in_an == in_bn);
        e.gt = !e.lt && !e.eq;
      end
      stna_pkg::CMD_DIV: begin
        e.dz  = in_dv == '0;
        e.neg = in_as[SEC_BITS-1];
        // magnitude of the seconds, most negative value included
        e.sec = in_as[SEC_BITS-1] ? (~in_as + SEC_BITS'(1)) : in_as;
      end
      stna_pkg::CMD_CYC: begin
        e.nlo = FW'(ns_borrow ? NW'(in_an + stna_pkg::NS_PER_SEC - in_bn)
                              : (in_an - in_bn));
      end
      default: begin
        e.cmd = in_cmd;
      end
    endcase
    pl_next[0] = e;

    for (int k = 1; k < NP; k++) begin
      pl_next[k] = pl[k-1];
    end

    for (int k = 0; k < SEC_BITS; k++) begin
      pl_next[k+1].rem = c1_rem[k];
      pl_next[k+1].sec = c1_dq[k];
    end

    // multiply stage: remainder times 1e9, or delta times frequency
    m = pl[MUL_I-1];
    if (m.cmd == stna_pkg::CMD_CYC) begin
      mx = cpu_freq_hz;
      my = m.nlo[NW-1:0];
    end else begin
      mx = {1'b0, m.rem[DW-1:0]};
      my = stna_pkg::NS_PER_SEC;
    end
    m.prod = PW'(mx) * PW'(my);
    if (m.cmd == stna_pkg::CMD_DIV) begin
      m.brw = m.neg && (m.rem != '0);
      if (m.neg) begin
        m.sec = ~m.sec + SEC_BITS'(1);
      end
    end
    pl_next[MUL_I] = m;

    // add stage: fold the nanoseconds in and set up the second division
    a   = pl[ADD_I-1];
    sum = a.prod;
    if (a.cmd == stna_pkg::CMD_DIV) begin
      sum = a.brw ? (a.prod - PW'(a.nsec)) : (a.prod + PW'(a.nsec));
    end
    if (a.cmd == stna_pkg::CMD_DIV || a.cmd == stna_pkg::CMD_CYC) begin
      a.rem = RW'(sum[PW-1:FW]);
      a.nlo = sum[FW-1:0];
    end
    if (a.cmd == stna_pkg::CMD_CYC) begin
      a.dv = DW'(stna_pkg::NS_PER_SEC);
    end
    pl_next[ADD_I] = a;

    for (int k = 0; k < FW; k++) begin
      pl_next[C2_I+k].rem = c2_rem[k];
      pl_next[C2_I+k].nlo = c2_dq[k];
    end
  end

  // result formatting
  always_comb begin
    stage_t f;
    f = pl[NP-1];
    res_sec_next     = '0;
    res_nsec_next    = '0;
    is_less_next     = 1'b0;
    is_equal_next    = 1'b0;
    is_greater_next  = 1'b0;
    cycle_count_next = '0;
    div_zero_next    = 1'b0;
    case (f.cmd)
      stna_pkg::CMD_ADD, stna_pkg::CMD_SUB: begin
        res_sec_next  = f.sec;
        res_nsec_next = f.nsec;
      end
      stna_pkg::CMD_CMP: begin
        is_less_next    = f.lt;
        is_equal_next   = f.eq;
        is_greater_next = f.gt;
      end
      stna_pkg::CMD_DIV: begin
        if (f.dz) begin
          div_zero_next = 1'b1;
        end else if (f.brw && (f.nlo != '0)) begin
          // negative nanoseconds: borrow one second
          res_sec_next  = f.sec - SEC_BITS'(1);
          res_nsec_next = stna_pkg::NS_PER_SEC - f.nlo[NW-1:0];
        end else begin
          res_sec_next  = f.sec;
          res_nsec_next = f.nlo[NW-1:0];
        end
      end
      stna_pkg::CMD_CYC: begin
        cycle_count_next = f.nlo;
      end
      default: begin
        div_zero_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NP-2:0], s_tvalid};
      m_tvalid <= vld[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NP; k++) begin
        pl[k] <= pl_next[k];
      end
      res_sec     <= res_sec_next;
      res_nsec    <= res_nsec_next;
      is_less     <= is_less_next;
      is_equal    <= is_equal_next;
      is_greater  <= is_greater_next;
      cycle_count <= cycle_count_next;
      div_zero    <= div_zero_next;
    end
  end

  assign m_tdata = OUT_TW'({div_zero, cycle_count, is_greater, is_equal, is_less,
                            res_nsec, res_sec});

`ifndef SYNTHESIS
  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_nsec <= stna_pkg::NSEC_MAX))
    else $error("result nanoseconds out of range");

  a_cmp_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones({is_less, is_equal, is_greater}) <= 1))
    else $error("more than one compare flag set");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && div_zero) |-> (res_sec == '0 && res_nsec == '0 && cycle_count == '0))
    else $error("divide by zero with nonzero result");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");
`endif

endmodule

/* bench/tb_sec_nsec_time_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sec_nsec_time_alu_core
// Self-checking bench for the timestamp ALU. Directed corner items, random
// mixes of all commands, a long output hold-off, and a sweep of cpu
// frequencies. Every result is compared with a local prediction, in order.
// ----------------------------------------------------------------------------
module tb_sec_nsec_time_alu_core;

  localparam int SB = 48;
  localparam int SW = ((2*SB+92+7)/8)*8;
  localparam int MW = ((SB+67+7)/8)*8;
  localparam int PIPE_LAT = SB + 36;
  localparam int NSW = stna_pkg::NSEC_W;
  localparam int FRW = stna_pkg::FREQ_W;
  localparam int DVW = stna_pkg::DIV_W;
  localparam logic [2:0] CMD_RSV_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSV_LAST  = 3'd7;
  localparam logic [SB-1:0] SEC_POS_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SEC_NEG_MAX = {1'b1, {(SB-1){1'b0}}};
  localparam logic [FRW-1:0] FREQ_TOP = {FRW{1'b1}};
  localparam longint NS_L = 64'd1000000000;

  typedef struct packed {
    logic [SB-1:0]  sec;
    logic [NSW-1:0] nsec;
    logic           lt;
    logic           eq;
    logic           gt;
    logic [FRW-1:0] cycles;
    logic           dz;
  } time_res_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_wr_en = 1'b0;
  logic [FRW-1:0] cfg_wr_data = '0;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [SW-1:0]  s_tdata = '0;
  logic [2:0]     s_tuser = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [MW-1:0]  m_tdata;

  time_res_t      expected_q[$];
  logic [FRW-1:0] freq_hz = stna_pkg::FREQ_RESET;
  int             errors = 0;
  int             results_seen = 0;
  int             cmd_count[8];
  int             tx_gap_max = 10;
  int             rx_stall_max = 10;
  int             rx_stall_left = 0;
  int             rx_hold_cycles = 0;

  always #6 clk = ~clk;

  sec_nsec_time_alu_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic logic [NSW-1:0] clamp_ns(logic [NSW-1:0] v);
    return (v > stna_pkg::NSEC_MAX) ? stna_pkg::NSEC_MAX : v;
  endfunction

  function automatic time_res_t predict_time_op(logic [2:0] cmd, logic [SB-1:0] as,
      logic [NSW-1:0] an_raw, logic [SB-1:0] bs, logic [NSW-1:0] bn_raw,
      logic [DVW-1:0] d);
    time_res_t r;
    longint sa, sbv, an, bn, s, n, dv, q, rm;
    longint unsigned delta;
    r = '0;
    sa = {{(64-SB){as[SB-1]}}, as};
    sbv = {{(64-SB){bs[SB-1]}}, bs};
    an = longint'(clamp_ns(an_raw));
    bn = longint'(clamp_ns(bn_raw));
    case (cmd)
      stna_pkg::CMD_ADD: begin
        s = sa + sbv;
        n = an + bn;
        if (n >= NS_L) begin
          s = s + 1;
          n = n - NS_L;
        end
        r.sec = s[SB-1:0];
        r.nsec = n[NSW-1:0];
      end
      stna_pkg::CMD_SUB: begin
        s = sa - sbv;
        if (an < bn) begin
          s = s - 1;
          n = an + NS_L - bn;
        end else begin
          n = an - bn;
        end
        r.sec = s[SB-1:0];
        r.nsec = n[NSW-1:0];
      end
      stna_pkg::CMD_CMP: begin
        r.lt = (sa < sbv) || (sa == sbv && an < bn);
        r.eq = (sa == sbv) && (an == bn);
        r.gt = !r.lt && !r.eq;
      end
      stna_pkg::CMD_DIV: begin
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          dv = longint'({32'b0, d});
          q = sa / dv;
          rm = sa % dv;
          n = (rm * NS_L + an) / dv;
          s = q;
          // negative nanoseconds: borrow a second to keep nsec in range
          if (n < 0) begin
            s = s - 1;
            n = n + NS_L;
          end
          r.sec = s[SB-1:0];
          r.nsec = n[NSW-1:0];
        end
      end
      stna_pkg::CMD_CYC: begin
        delta = (an < bn) ? longint'(NS_L + an - bn) : longint'(an - bn);
        delta = delta * longint'({31'b0, freq_hz}) / NS_L;
        r.cycles = delta[FRW-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_op(logic [2:0] cmd, logic [SB-1:0] as, logic [NSW-1:0] an,
      logic [SB-1:0] bs, logic [NSW-1:0] bn, logic [DVW-1:0] d);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {4'b0, d, bn, bs, an, as};
    s_tuser <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(predict_time_op(cmd, as, an, bs, bn, d));
    cmd_count[cmd]++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (PIPE_LAT + 8) @(negedge clk);
  endtask

  task automatic write_freq(logic [FRW-1:0] f);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    freq_hz = f;
  endtask

  function automatic logic [SB-1:0] rand_sec();
    logic [SB-1:0] v;
    case ($urandom_range(0, 5))
      0: v = SEC_POS_MAX - $urandom_range(0, 3);
      1: v = SEC_NEG_MAX + $urandom_range(0, 3);
      2: v = SB'($signed($urandom_range(0, 2000)) - 1000);
      default: v = SB'({$urandom(), $urandom()});
    endcase
    return v;
  endfunction

  function automatic logic [NSW-1:0] rand_ns();
    case ($urandom_range(0, 9))
      0: return NSW'($urandom());
      1: return NSW'(stna_pkg::NSEC_MAX - $urandom_range(0, 2));
      2: return NSW'($urandom_range(0, 2));
      default: return NSW'($urandom_range(0, 999999999));
    endcase
  endfunction

  function automatic logic [DVW-1:0] rand_div();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DVW'($urandom_range(1, 16));
      2: return {DVW{1'b1}} - $urandom_range(0, 2);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(int count);
    logic [2:0] cmd;
    logic [SB-1:0] as;
    repeat (count) begin
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CMD_RSV_FIRST, CMD_RSV_LAST))
                                         : 3'($urandom_range(stna_pkg::CMD_ADD,
                                                             stna_pkg::CMD_CYC));
      as = rand_sec();
      // equal seconds now and then so compare reaches the nanosecond tie-break
      send_op(cmd, as, rand_ns(), ($urandom_range(0, 3) == 0) ? as : rand_sec(),
              rand_ns(), rand_div());
    end
  endtask

  task automatic test_directed();
    send_op(stna_pkg::CMD_ADD, 48'd1, 30'd600000000, 48'd2, 30'd400000000, '0);
    send_op(stna_pkg::CMD_ADD, SEC_POS_MAX, stna_pkg::NSEC_MAX, 48'd0, 30'd1, '0);
    send_op(stna_pkg::CMD_ADD, SEC_NEG_MAX, {NSW{1'b1}}, SEC_NEG_MAX, {NSW{1'b1}}, '0);
    send_op(stna_pkg::CMD_SUB, 48'd5, 30'd100, 48'd2, 30'd200, '0);
    send_op(stna_pkg::CMD_SUB, SEC_NEG_MAX, 30'd0, 48'd1, stna_pkg::NSEC_MAX, '0);
    send_op(stna_pkg::CMD_SUB, 48'd3, {NSW{1'b1}}, 48'd3, 30'd5, '0);
    send_op(stna_pkg::CMD_CMP, 48'd7, 30'd5, 48'd7, 30'd5, '0);
    send_op(stna_pkg::CMD_CMP, 48'd7, 30'd4, 48'd7, 30'd5, '0);
    send_op(stna_pkg::CMD_CMP, 48'd7, {NSW{1'b1}}, 48'd7, stna_pkg::NSEC_MAX, '0);
    send_op(stna_pkg::CMD_CMP, SEC_NEG_MAX, stna_pkg::NSEC_MAX, SEC_POS_MAX, 30'd0, '0);
    send_op(stna_pkg::CMD_CMP, SEC_POS_MAX, 30'd0, SEC_NEG_MAX, stna_pkg::NSEC_MAX, '0);
    send_op(stna_pkg::CMD_DIV, 48'd10, 30'd500, 48'd0, 30'd0, '0);
    send_op(stna_pkg::CMD_DIV, 48'd10, 30'd500, 48'd0, 30'd0, 32'd3);
    send_op(stna_pkg::CMD_DIV, -48'sd7, 30'd0, 48'd0, 30'd0, 32'd2);
    send_op(stna_pkg::CMD_DIV, SEC_NEG_MAX, {NSW{1'b1}}, 48'd0, 30'd0, 32'd1);
    send_op(stna_pkg::CMD_DIV, SEC_POS_MAX, stna_pkg::NSEC_MAX, 48'd0, 30'd0, {DVW{1'b1}});
    send_op(stna_pkg::CMD_DIV, SEC_NEG_MAX, stna_pkg::NSEC_MAX, 48'd0, 30'd0, {DVW{1'b1}});
    send_op(stna_pkg::CMD_CYC, 48'd9, 30'd100, 48'd9, 30'd900, '0);
    send_op(stna_pkg::CMD_CYC, 48'd0, stna_pkg::NSEC_MAX, 48'd0, 30'd0, '0);
    send_op(stna_pkg::CMD_CYC, 48'd0, {NSW{1'b1}}, 48'd0, {NSW{1'b1}}, '0);
    for (int k = int'(CMD_RSV_FIRST); k <= int'(CMD_RSV_LAST); k++) begin
      send_op(3'(k), SEC_POS_MAX, stna_pkg::NSEC_MAX, SEC_NEG_MAX, 30'd1, {DVW{1'b1}});
    end
  endtask

  task automatic test_back_to_back();
    tx_gap_max = 0;
    rx_stall_max = 0;
    send_random(150);
    tx_gap_max = 10;
    rx_stall_max = 10;
  endtask

  task automatic test_output_hold();
    // long hold-off while the sender keeps pushing, so the pipeline backs up
    @(negedge clk);
    s_tvalid <= 1'b0;
    rx_hold_cycles = 300;
    tx_gap_max = 0;
    send_random(200);
    tx_gap_max = 10;
  endtask

  task automatic test_sender_pause();
    send_random(100);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    send_random(100);
  endtask

  task automatic test_freq_sweep();
    logic [FRW-1:0] freqs[5];
    freqs = '{33'd1, FREQ_TOP, 33'd2500000000, 33'd12345, stna_pkg::FREQ_RESET};
    foreach (freqs[i]) begin
      write_freq(freqs[i]);
      send_op(stna_pkg::CMD_CYC, '0, stna_pkg::NSEC_MAX, '0, 30'd0, '0);
      send_op(stna_pkg::CMD_CYC, '0, 30'd0, '0, stna_pkg::NSEC_MAX, '0);
      send_random(60);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    time_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.sec = m_tdata[47:0];
      got.nsec = m_tdata[77:48];
      got.lt = m_tdata[78];
      got.eq = m_tdata[79];
      got.gt = m_tdata[80];
      got.cycles = m_tdata[113:81];
      got.dz = m_tdata[114];
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result item with no expectation pending: %h", m_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.sec !== want.sec) begin
          $error("res_sec exp %h got %h", want.sec, got.sec); errors++;
        end
        if (got.nsec !== want.nsec) begin
          $error("res_nsec exp %0d got %0d", want.nsec, got.nsec); errors++;
        end
        if (got.lt !== want.lt) begin
          $error("is_less exp %b got %b", want.lt, got.lt); errors++;
        end
        if (got.eq !== want.eq) begin
          $error("is_equal exp %b got %b", want.eq, got.eq); errors++;
        end
        if (got.gt !== want.gt) begin
          $error("is_greater exp %b got %b", want.gt, got.gt); errors++;
        end
        if (got.cycles !== want.cycles) begin
          $error("cycle_count exp %0d got %0d", want.cycles, got.cycles); errors++;
        end
        if (got.dz !== want.dz) begin
          $error("div_zero exp %b got %b", want.dz, got.dz); errors++;
        end
      end
      rx_stall_left = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
    end
  end

  // output ready driver; the long hold-off is counted here
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        m_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL sec_nsec_time_alu_core");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_freq(33'd3000000000);
    test_directed();
    write_freq(stna_pkg::FREQ_RESET);
    test_back_to_back();
    test_output_hold();
    test_sender_pause();
    test_freq_sweep();
    send_random(330);
    drain_results();
    $display("covered %0d results: add %0d sub %0d cmp %0d div %0d cyc %0d reserved %0d",
             results_seen, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
             cmd_count[4], cmd_count[5] + cmd_count[6] + cmd_count[7]);
    $display("with output hold-off, back-to-back items and six cpu frequency settings");
    if (errors == 0) begin
      $display("PASS sec_nsec_time_alu_core");
    end else begin
      $display("FAIL sec_nsec_time_alu_core");
    end
    $finish;
  end

endmodule
